// ===== rtl/core/itd_pkg.sv =====
// itd_pkg: shared widths, character codes, controller states and
// command/status structs for the decimal text converter
// no dependencies
package itd_pkg;

    // converted word width, the input word is cut or zero-extended to it
    localparam int VALUE_BITS = 32;
    localparam int IN_BITS    = 32;
    // decimal digits needed for 2^VALUE_BITS - 1 (floor(bits*log10(2)) + 1)
    localparam int DIGITS     = ((VALUE_BITS * 1233) >>> 12) + 1;
    localparam int BCD_W      = DIGITS * 4;
    localparam int PTR_W      = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam int CNT_W      = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_MINUS = 8'd45;
    // double-dabble correction
    localparam logic [3:0] ADJ_MIN  = 4'd5;
    localparam logic [3:0] ADJ_ADD  = 4'd3;

    typedef logic [VALUE_BITS-1:0] t_word;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_FIND,
        S_SIGN,
        S_DIGITS
    } t_state;

    typedef struct packed {
        logic load;      // take a new word and mode
        logic shift;     // one double-dabble step
        logic set_ptr;   // point at the leading nonzero digit
        logic dec_ptr;   // move to the next lower digit
        logic sel_sign;  // output shows '-'
    } t_cmd;

    typedef struct packed {
        logic conv_last; // this shift is the final one
        logic neg;       // word was negative in signed mode
        logic ptr_zero;  // pointer at the units digit
    } t_sts;

endpackage

// ===== rtl/core/integer_to_decimal_ascii_top.sv =====
// integer_to_decimal_ascii_top: word to decimal ascii text converter
// the first character follows the word through 32 shift-and-add-3 steps of the bcd
//   converter and one leading-digit pick
// the bcd converter handles one word at a time, taking no new word until the last character
//   of the number is taken, and then sends one character a cycle while m_tready is high
// reset: synchronous active-low i_rst_n returns the controller to idle, no item pending
module integer_to_decimal_ascii_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input item stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [itd_pkg::IN_BITS-1:0] s_tdata,  // [31:0] value
    input  logic [0:0]                  s_tuser,  // [0] op: 0 unsigned, 1 signed
    // output character stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata,  // [7:0] char_out
    output logic                        m_tlast   // last character of the number
);
    import itd_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequencing: idle, convert, pick leading digit, sign, digits
    itd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_tvalid),
        .o_in_ready  (s_tready),
        .o_out_valid (m_tvalid),
        .i_out_ready (m_tready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // magnitude, bcd digits and the character shown on the output
    itd_datapath u_dp (
        .i_clk   (i_clk),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .i_op    (s_tuser[0]),
        .i_value (s_tdata),
        .o_char  (m_tdata),
        .o_last  (m_tlast)
    );

endmodule

// ===== rtl/core/itd_ctrl.sv =====
// itd_ctrl: controller state machine of the decimal text converter
// depends on itd_pkg
module itd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output itd_pkg::t_cmd o_cmd,
    input  itd_pkg::t_sts i_sts
);
    import itd_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CONV;
                end
            end
            S_CONV: begin
                o_cmd.shift = 1'b1;
                if (i_sts.conv_last) begin
                    n_state = S_FIND;
                end
            end
            S_FIND: begin
                o_cmd.set_ptr = 1'b1;
                n_state       = i_sts.neg ? S_SIGN : S_DIGITS;
            end
            S_SIGN: begin
                o_out_valid    = 1'b1;
                o_cmd.sel_sign = 1'b1;
                if (i_out_ready) begin
                    n_state = S_DIGITS;
                end
            end
            S_DIGITS: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_sts.ptr_zero) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.dec_ptr = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/itd_datapath.sv =====
// itd_datapath: sign fix, shift-and-add-3 binary to bcd, digit pointer
// and character forming; depends on itd_pkg
module itd_datapath (
    input  logic                          i_clk,
    input  itd_pkg::t_cmd                 i_cmd,
    output itd_pkg::t_sts                 o_sts,
    input  logic                          i_op,
    input  logic [itd_pkg::IN_BITS-1:0]   i_value,
    output logic [7:0]                    o_char,
    output logic                          o_last
);
    import itd_pkg::*;

    t_word             r_bin;
    logic [BCD_W-1:0]  r_bcd;
    logic [CNT_W-1:0]  r_cnt;
    logic [PTR_W-1:0]  r_ptr;
    logic              r_neg;

    t_word             word;
    t_word             mag;
    logic              neg;
    logic [BCD_W-1:0]  adj;
    logic [PTR_W-1:0]  top;
    logic [3:0]        digit;

    // magnitude of the incoming word
    always_comb begin
        word = t_word'(i_value);
        neg  = i_op & word[VALUE_BITS-1];
        mag  = neg ? (~word + t_word'(1)) : word;
    end

    // add 3 to every bcd digit of five or more before the shift
    always_comb begin
        for (int i = 0; i < DIGITS; i++) begin
            adj[i*4 +: 4] = r_bcd[i*4 +: 4]
                          + ((r_bcd[i*4 +: 4] >= ADJ_MIN) ? ADJ_ADD : 4'd0);
        end
    end

    // highest nonzero digit, units digit when all are zero
    always_comb begin
        top = '0;
        for (int i = 0; i < DIGITS; i++) begin
            if (r_bcd[i*4 +: 4] != 4'd0) begin
                top = PTR_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bin <= mag;
            r_bcd <= '0;
            r_cnt <= '0;
            r_neg <= neg;
        end else if (i_cmd.shift) begin
            r_bin <= {r_bin[VALUE_BITS-2:0], 1'b0};
            r_bcd <= {adj[BCD_W-2:0], r_bin[VALUE_BITS-1]};
            r_cnt <= r_cnt + CNT_W'(1);
        end
        if (i_cmd.set_ptr) begin
            r_ptr <= top;
        end else if (i_cmd.dec_ptr) begin
            r_ptr <= r_ptr - PTR_W'(1);
        end
    end

    assign digit          = r_bcd[r_ptr*4 +: 4];
    assign o_char         = i_cmd.sel_sign ? CH_MINUS : (CH_ZERO + {4'd0, digit});
    assign o_last         = ~i_cmd.sel_sign & o_sts.ptr_zero;
    assign o_sts.conv_last = (r_cnt == CNT_W'(VALUE_BITS - 1));
    assign o_sts.neg      = r_neg;
    assign o_sts.ptr_zero = (r_ptr == '0);

endmodule

// ===== rtl/core/itd_checker.sv =====
// itd_checker: port-level checks on the decimal text converter
// depends on itd_pkg, bound to integer_to_decimal_ascii_top
module itd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);
    import itd_pkg::*;

    // a held character keeps its value and mark
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output item changed while stalled");

    // only '-' or a decimal digit leaves
    a_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tdata == CH_MINUS)
                  || (m_tdata >= CH_ZERO && m_tdata <= CH_ZERO + 8'd9))
        else $error("character out of range");

    // a minus sign is always followed by digits
    a_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tdata == CH_MINUS |-> !m_tlast)
        else $error("minus marked last");

    // one word at a time: no input taken while characters are out
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_tready && m_tvalid))
        else $error("input ready during output");

    // after the last character is taken the converter is free again
    a_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tready && m_tlast |=> s_tready)
        else $error("not ready after last character");

endmodule

bind integer_to_decimal_ascii_top itd_checker u_itd_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ===== sim/integer_to_decimal_ascii_top_tb.sv =====
// integer_to_decimal_ascii_top_tb: self-checking bench for the word to decimal text converter
// predicts each number's character run and checks it against the output stream
// depends on itd_pkg and integer_to_decimal_ascii_top
module integer_to_decimal_ascii_top_tb;

    import itd_pkg::*;

    typedef enum bit {
        OP_UNSIGNED = 1'b0,
        OP_SIGNED   = 1'b1
    } t_conv_mode;

    typedef struct {
        t_conv_mode         op;
        logic [IN_BITS-1:0] value;
    } t_word_item;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } t_text_char;

    localparam int TAIL_CYCLES  = VALUE_BITS + 32;
    localparam int LIMIT_CYCLES = 600000;
    localparam int HOLD_CYCLES  = 600;

    logic               i_clk    = 1'b0;
    logic               i_rst_n  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [IN_BITS-1:0] s_tdata  = '0;  // [31:0] value
    logic [0:0]         s_tuser  = '0;  // [0] op: 0 unsigned, 1 signed
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [7:0]         m_tdata;        // [7:0] char_out
    logic               m_tlast;

    t_word_item pending_words[$];
    t_text_char expected_text[$];

    int words_queued  = 0;
    int words_sent    = 0;
    int words_taken   = 0;
    int error_count   = 0;
    int tx_idle_pct   = 0;
    int rx_stall_pct  = 0;
    int rx_hold_left  = 0;
    bit hold_go       = 1'b0;

    integer_to_decimal_ascii_top uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // expected text of one number: optional minus, then digits, msd first
    function automatic void push_decimal_text(input t_conv_mode op,
                                              input logic [IN_BITS-1:0] data);
        t_word      word;
        t_word      negated;
        logic [63:0] mag;
        logic [3:0] digits[$];
        bit         neg;
        t_text_char entry;
        word = t_word'(data);
        neg  = (op == OP_SIGNED) && word[VALUE_BITS-1];
        negated = ~word + 1'b1;
        // the most negative word negates to itself, which read unsigned is its magnitude
        mag = neg ? 64'(negated) : 64'(word);
        if (mag == 0) begin
            entry.ch   = CH_ZERO;
            entry.last = 1'b1;
            expected_text.push_back(entry);
            return;
        end
        while (mag != 0) begin
            digits.push_front(4'(mag % 10));
            mag = mag / 10;
        end
        if (neg) begin
            entry.ch   = CH_MINUS;
            entry.last = 1'b0;
            expected_text.push_back(entry);
        end
        foreach (digits[i]) begin
            entry.ch   = CH_ZERO + 8'(digits[i]);
            entry.last = (i == digits.size() - 1);
            expected_text.push_back(entry);
        end
    endfunction

    // sender: holds an item until it is taken, idles at random between items
    always @(negedge i_clk) begin : drive_words
        t_word_item next_word;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || words_taken == words_sent) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                next_word = pending_words.pop_front();
                words_sent++;
                s_tvalid <= 1'b1;
                s_tdata  <= next_word.value;
                s_tuser  <= next_word.op;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // long receiver hold-off, counted in cycles here once started
    initial begin : long_hold
        wait (hold_go);
        rx_hold_left = HOLD_CYCLES;
        while (rx_hold_left != 0) begin
            @(negedge i_clk);
            rx_hold_left = rx_hold_left - 1;
        end
    end

    // receiver: random stalls, held off while the long hold runs
    always @(negedge i_clk) begin
        if (rx_hold_left != 0) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // monitor: predict on each taken item, check each sent character
    always @(posedge i_clk) begin : watch_streams
        t_text_char want;
        if (i_rst_n) begin
            if (s_tvalid && s_tready) begin
                push_decimal_text(t_conv_mode'(s_tuser[0]), s_tdata);
                words_taken++;
            end
            if (m_tvalid && m_tready) begin
                if (expected_text.size() == 0) begin
                    $error("char_out: none expected, actual %0d", m_tdata);
                    error_count++;
                end else begin
                    want = expected_text.pop_front();
                    if (m_tdata !== want.ch) begin
                        $error("char_out: expected %0d, actual %0d", want.ch, m_tdata);
                        error_count++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last: expected %0d, actual %0d", want.last, m_tlast);
                        error_count++;
                    end
                end
            end
        end
    end

    task automatic add_word(input t_conv_mode op, input logic [IN_BITS-1:0] value);
        t_word_item w;
        w.op    = op;
        w.value = value;
        pending_words.push_back(w);
        words_queued++;
    endtask

    // random words spread over digit counts, signs and edges
    task automatic add_random_word();
        logic [IN_BITS-1:0] v;
        longint unsigned    lim;
        int                 k;
        lim = 1;
        k   = $urandom_range(1, 9);
        repeat (k) lim = lim * 10;
        case ($urandom_range(9))
            0, 1, 2, 3: v = $urandom;
            4, 5:       v = IN_BITS'($urandom % lim);
            6:          v = -IN_BITS'($urandom % lim);
            7: begin
                // around a power of ten, either sign
                lim = lim / 10;
                v = IN_BITS'(lim) + $urandom_range(2) - 1;
                if ($urandom_range(1)) v = -v;
            end
            8:          v = 32'h7FFF_FFFE + $urandom_range(3);
            default:    v = $urandom_range(1) ? '1 : '0;
        endcase
        add_word(t_conv_mode'($urandom_range(1)), v);
    endtask

    task automatic wait_drained();
        while (words_taken != words_queued || expected_text.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic run_phase(input int n, input int tx_pct, input int rx_pct);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        repeat (n) add_random_word();
        wait_drained();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero in both modes, single digits, widest words, sign edges
        add_word(OP_UNSIGNED, 32'd0);
        add_word(OP_SIGNED,   32'd0);
        add_word(OP_UNSIGNED, 32'd1);
        add_word(OP_SIGNED,   32'd1);
        add_word(OP_UNSIGNED, 32'd9);
        add_word(OP_UNSIGNED, 32'd10);
        add_word(OP_SIGNED,   32'd99);
        add_word(OP_UNSIGNED, 32'd999999999);
        add_word(OP_UNSIGNED, 32'd1000000000);
        add_word(OP_UNSIGNED, 32'hFFFF_FFFF);
        add_word(OP_SIGNED,   32'hFFFF_FFFF);
        add_word(OP_SIGNED,   32'h7FFF_FFFF);
        add_word(OP_UNSIGNED, 32'h7FFF_FFFF);
        // most negative word must print its full magnitude
        add_word(OP_SIGNED,   32'h8000_0000);
        add_word(OP_UNSIGNED, 32'h8000_0000);
        add_word(OP_SIGNED,   32'h8000_0001);
        add_word(OP_SIGNED,   32'hFFFF_FFF6);
        add_word(OP_UNSIGNED, 32'hAAAA_AAAA);
        add_word(OP_SIGNED,   32'h5555_5555);
        add_word(OP_SIGNED,   32'hAAAA_AAAA);
        wait_drained();

        run_phase(100, 0, 0);
        run_phase(100, 73, 0);
        run_phase(100, 0, 73);
        run_phase(100, 6, 6);

        // long receiver hold-off while words keep coming, block backs up
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_go      = 1'b1;
        repeat (60) add_random_word();
        wait_drained();

        run_phase(40, 0, 0);

        rx_stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("[integer_to_decimal_ascii_top] OK");
        end else begin
            $display("[integer_to_decimal_ascii_top] ERROR");
        end
        $finish;
    end

    // hang guard, far beyond the slowest correct run
    initial begin
        #(LIMIT_CYCLES * 4);
        $display("[integer_to_decimal_ascii_top] ERROR");
        $finish;
    end

endmodule
